// ----- design/utd_pkg.sv -----
// Types and constants shared by the UTF-8 to UCS-2 decoder.
// No dependencies; compiled first.
package utd_pkg;

  localparam logic [7:0]  ASCII_LIMIT   = 8'h80;
  localparam logic [7:0]  MASK_LEAD2    = 8'hE0;
  localparam logic [7:0]  CODE_LEAD2    = 8'hC0;
  localparam logic [7:0]  MASK_LEAD3    = 8'hF0;
  localparam logic [7:0]  CODE_LEAD3    = 8'hE0;
  localparam logic [7:0]  MASK_LEAD4    = 8'hF8;
  localparam logic [7:0]  CODE_LEAD4    = 8'hF0;
  localparam logic [7:0]  PAYLOAD_LEAD2 = 8'h1F;
  localparam logic [7:0]  PAYLOAD_LEAD3 = 8'h0F;
  localparam logic [7:0]  PAYLOAD_CONT  = 8'h3F;
  localparam logic [1:0]  PEND_LEAD2    = 2'd1;
  localparam logic [1:0]  PEND_LEAD3    = 2'd2;
  localparam logic [1:0]  PEND_LEAD4    = 2'd3;
  localparam logic [15:0] CHAR_LIMIT_RST = 16'hFFFF;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  bytes_pending;
    logic        skipping;
    logic [15:0] partial_value;
    logic [15:0] chars_done;
  } utd_state_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last;
  } utd_word_t;

  // Up to two words per byte; the second one is always the terminator.
  typedef struct packed {
    logic [1:0] count;
    utd_word_t  first;
  } utd_res_t;

  localparam utd_word_t TERM_WORD = '{code_unit: 16'h0000, last: 1'b1};

endpackage

// ----- design/utd_if.sv -----
// Valid/ready channel interfaces of the decoder: byte input, word output,
// configuration write. Depends on nothing.
interface utd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface utd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last;
  modport source (output valid, output code_unit, output last, input ready);
  modport sink   (input valid, input code_unit, input last, output ready);
endinterface

interface utd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_limit;
  modport source (output valid, output char_limit, input ready);
  modport sink   (input valid, input char_limit, output ready);
endinterface

// ----- design/utd_step.sv -----
// Decode logic for one byte: next string state and the words it emits.
// Depends on utd_pkg.
module utd_step import utd_pkg::*; (
  input  utd_state_t  st,
  input  logic [7:0]  in_byte,
  input  logic [15:0] char_limit,
  output utd_state_t  st_nxt,
  output utd_res_t    res
);

  always_comb begin
    logic [15:0] chars_inc;
    logic [1:0]  pend_dec;
    logic [15:0] pv_shift;
    logic        count_en;
    logic        emit_unit;
    logic [15:0] unit;
    logic        term;
    logic        forced;

    chars_inc = st.chars_done + 16'd1;
    pend_dec  = st.bytes_pending - 2'd1;
    pv_shift  = st.skipping ? st.partial_value
                            : {st.partial_value[9:0], in_byte[5:0] & PAYLOAD_CONT[5:0]};
    st_nxt    = st;
    count_en  = 1'b0;
    emit_unit = 1'b0;
    unit      = 16'h0000;
    term      = 1'b0;

    if (st.bytes_pending != 2'd0) begin
      st_nxt.bytes_pending = pend_dec;
      st_nxt.partial_value = pv_shift;
      if (pend_dec == 2'd0) begin
        emit_unit            = !st.skipping;
        unit                 = pv_shift;
        count_en             = 1'b1;
        st_nxt.skipping      = 1'b0;
        st_nxt.partial_value = 16'h0000;
      end
    end else begin
      priority if (in_byte == 8'h00) begin
        term = 1'b1;
      end else if (in_byte < ASCII_LIMIT) begin
        emit_unit = 1'b1;
        unit      = {8'h00, in_byte};
        count_en  = 1'b1;
      end else if ((in_byte & MASK_LEAD2) == CODE_LEAD2) begin
        st_nxt.partial_value = {8'h00, in_byte & PAYLOAD_LEAD2};
        st_nxt.bytes_pending = PEND_LEAD2;
      end else if ((in_byte & MASK_LEAD3) == CODE_LEAD3) begin
        st_nxt.partial_value = {8'h00, in_byte & PAYLOAD_LEAD3};
        st_nxt.bytes_pending = PEND_LEAD3;
      end else if ((in_byte & MASK_LEAD4) == CODE_LEAD4) begin
        st_nxt.skipping      = 1'b1;
        st_nxt.bytes_pending = PEND_LEAD4;
      end else begin
        count_en = 1'b1;
      end
    end

    forced = count_en && (chars_inc >= char_limit);
    if (count_en) begin
      st_nxt.chars_done = chars_inc;
    end
    if (term || forced) begin
      st_nxt = '0;
    end

    res.count           = {1'b0, emit_unit} + {1'b0, term || forced};
    res.first.code_unit = emit_unit ? unit : 16'h0000;
    res.first.last      = !emit_unit && (term || forced);
  end

endmodule

// ----- design/utd_queue.sv -----
// Four-entry result queue: takes up to two words per cycle, gives one while the output is ready.
// Depends on utd_pkg.
module utd_queue import utd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  utd_res_t  push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output utd_word_t out_word
);

  utd_word_t             mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]     cnt_r, cnt_nxt;
  logic                  pop;

  assign pop        = (cnt_r != '0) && out_ready;
  assign out_valid  = (cnt_r != '0);
  assign out_word   = mem_r[rd_ptr_r];
  assign room       = (cnt_r <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
  assign wr_ptr_nxt = wr_ptr_r + QUEUE_AW'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + QUEUE_AW'(pop);
  assign cnt_nxt    = cnt_r + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_r + QUEUE_AW'(1)] <= TERM_WORD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/utf8_to_ucs2_decoder_top.sv -----
// Top level of the UTF-8 to UCS-2 decoder.
// Depends on utd_pkg, utd_if, utd_step, utd_queue.
// Takes one byte per clock unless stalled. Each accepted byte is held in the
// input register, then a single pass of decode logic updates the string state
// and pushes zero, one or two words into a four-entry result queue, which the
// output channel drains one word per clock while the output is ready. Input
// stalls only while the queue has fewer than two free entries, so with the
// output always ready it stalls only once two-word results fill the queue. A
// byte that completes a character at the char_limit limit yields its code unit
// followed directly by the terminator; a skipped or invalid character there
// yields the terminator alone.
// char_limit resets to 65535 and may be written only while the block is idle.
module utf8_to_ucs2_decoder_top import utd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  utd_in_if.sink    in_ch,
  utd_out_if.source out_ch,
  utd_cfg_if.sink   cfg_ch
);

  logic        byte_vld_r, byte_vld_nxt;
  logic [7:0]  byte_r;
  logic [15:0] char_limit_r;
  utd_state_t  st_r, st_nxt;
  utd_state_t  step_st;
  utd_res_t    step_res, push;
  utd_word_t   out_word;
  logic        room;
  logic        adv;
  logic        in_fire;

  assign adv          = byte_vld_r && room;
  assign in_ch.ready  = !byte_vld_r || room;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign byte_vld_nxt = in_fire || (byte_vld_r && !adv);
  assign cfg_ch.ready = 1'b1;

  utd_step u_step (
    .st         (st_r),
    .in_byte    (byte_r),
    .char_limit (char_limit_r),
    .st_nxt     (step_st),
    .res        (step_res)
  );

  assign st_nxt = adv ? step_st : st_r;

  always_comb begin
    push = step_res;
    if (!adv) begin
      push.count = 2'd0;
    end
  end

  utd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.code_unit = out_word.code_unit;
  assign out_ch.last      = out_word.last;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_ch.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r   <= 1'b0;
      st_r         <= '0;
      char_limit_r <= CHAR_LIMIT_RST;
    end else begin
      byte_vld_r <= byte_vld_nxt;
      st_r       <= st_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        char_limit_r <= cfg_ch.char_limit;
      end
    end
  end

endmodule

// ----- design/utd_checker.sv -----
// Port-level checks on the decoder, attached to the top level by bind.
// Depends on utf8_to_ucs2_decoder_top and its interface ports.
module utd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_code_unit,
  input logic        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_unit) && $stable(out_last))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present right after reset");

  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_code_unit == 16'h0000)
    else $error("terminator word is not zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no output pending");

endmodule

bind utf8_to_ucs2_decoder_top utd_checker u_utd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_code_unit (out_ch.code_unit),
  .out_last      (out_ch.last)
);
